/* design/dpod_pkg.sv */
// Shared types, constants and functions of the date period overlap block.
package dpod_pkg;

    localparam int YEAR_W = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W = 5;
    localparam int ORD_W = 23;
    localparam int COUNT_W = 22;
    localparam int IN_DATA_W = 96;
    localparam int OUT_DATA_W = 24;
    localparam int DEF_YEAR_LIMIT = 9999;
    localparam int STAGES = 5;

    localparam logic [8:0] DAYS_YEAR = 9'd365;
    localparam logic [27:0] RECIP100 = 28'd5243;
    localparam logic [6:0] CENTURY = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0] day;
    } date_t;

    typedef struct packed {
        logic [STAGES-1:0] ld;
    } pipe_ctl_t;

    function automatic logic [8:0] months_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd0: r = 9'd0;
                4'd1: r = 9'd0;
                4'd2: r = 9'd31;
                4'd3: r = 9'd59;
                4'd4: r = 9'd90;
                4'd5: r = 9'd120;
                4'd6: r = 9'd151;
                4'd7: r = 9'd181;
                4'd8: r = 9'd212;
                4'd9: r = 9'd243;
                4'd10: r = 9'd273;
                4'd11: r = 9'd304;
                4'd12: r = 9'd334;
                default: r = 9'd365;
            endcase
            return r;
        end
    endfunction

endpackage

/* design/dpod_ordinal.sv */
// Two-stage conversion of one Gregorian date into a day ordinal.
module dpod_ordinal #(
    parameter int YEAR_LIMIT = dpod_pkg::DEF_YEAR_LIMIT
) (
    input  logic                            clk,
    input  dpod_pkg::pipe_ctl_t             ctl,
    input  dpod_pkg::date_t                 date,
    output logic [dpod_pkg::ORD_W-1:0]      ordinal
);

    logic [dpod_pkg::YEAR_W-1:0] y_clamp;
    logic [27:0] prod_a;
    logic [27:0] prod_b;
    logic [27:0] prod_c;
    logic [dpod_pkg::YEAR_W-1:0] y_reg;
    logic [dpod_pkg::MONTH_W-1:0] m_reg;
    logic [dpod_pkg::DAY_W-1:0] d_reg;
    logic [7:0] q100a_reg;
    logic [5:0] q400_reg;
    logic [7:0] q100y_reg;
    logic leap;
    logic [dpod_pkg::ORD_W-1:0] ord_next;
    logic [dpod_pkg::ORD_W-1:0] ord_reg;

    always_comb
    begin
        if (32'(date.year) > YEAR_LIMIT)
            y_clamp = dpod_pkg::YEAR_W'(YEAR_LIMIT);
        else
            y_clamp = date.year;
        prod_a = (28'(y_clamp) + 28'd99) * dpod_pkg::RECIP100;
        prod_b = ((28'(y_clamp) + 28'd399) >> 2) * dpod_pkg::RECIP100;
        prod_c = 28'(y_clamp) * dpod_pkg::RECIP100;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            y_reg <= y_clamp;
            m_reg <= date.month;
            d_reg <= date.day;
            q100a_reg <= prod_a[26:19];
            q400_reg <= prod_b[24:19];
            q100y_reg <= prod_c[26:19];
        end
    end

    always_comb
    begin
        leap = (y_reg[1:0] == 2'd0) &&
               ((15'(q100y_reg) * 15'(dpod_pkg::CENTURY) != 15'(y_reg)) ||
                (q100y_reg[1:0] == 2'd0));
        ord_next = dpod_pkg::ORD_W'(y_reg) * dpod_pkg::ORD_W'(dpod_pkg::DAYS_YEAR)
                 + dpod_pkg::ORD_W'((15'(y_reg) + 15'd3) >> 2)
                 - dpod_pkg::ORD_W'(q100a_reg)
                 + dpod_pkg::ORD_W'(q400_reg)
                 + dpod_pkg::ORD_W'(dpod_pkg::months_before(m_reg))
                 + dpod_pkg::ORD_W'(leap && (m_reg >= 4'd3))
                 + dpod_pkg::ORD_W'(d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[1])
            ord_reg <= ord_next;
    end

    assign ordinal = ord_reg;

endmodule

/* design/dpod_overlap.sv */
// Three-stage overlap count of two periods given as day ordinals.
module dpod_overlap (
    input  logic                            clk,
    input  dpod_pkg::pipe_ctl_t             ctl,
    input  logic [dpod_pkg::ORD_W-1:0]      s1,
    input  logic [dpod_pkg::ORD_W-1:0]      e1,
    input  logic [dpod_pkg::ORD_W-1:0]      s2,
    input  logic [dpod_pkg::ORD_W-1:0]      e2,
    output logic [dpod_pkg::COUNT_W-1:0]    count
);

    localparam int W = dpod_pkg::ORD_W;

    logic [W-1:0] s1_reg, e1_reg, s2_reg, e2_reg;
    logic [W-1:0] len1_reg, len2_reg;
    logic inter_reg;
    logic [W-1:0] ws, we, os, oe;
    logic [W-1:0] lo_next, hi_next;
    logic [W-1:0] lo_reg, hi_reg;
    logic go_reg;
    logic [W-1:0] span;
    logic [dpod_pkg::COUNT_W-1:0] count_next;
    logic [dpod_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ld[2])
        begin
            s1_reg <= s1;
            e1_reg <= e1;
            s2_reg <= s2;
            e2_reg <= e2;
            inter_reg <= !((e1 < s2) || (e2 < s1));
            len1_reg <= (s1 < e1) ? e1 - s1 : '0;
            len2_reg <= (s2 < e2) ? e2 - s2 : '0;
        end
    end

    always_comb
    begin
        if (len1_reg < len2_reg)
        begin
            ws = s1_reg;
            we = e1_reg;
            os = s2_reg;
            oe = e2_reg;
        end
        else
        begin
            ws = s2_reg;
            we = e2_reg;
            os = s1_reg;
            oe = e1_reg;
        end
        lo_next = (ws > os) ? ws : os;
        hi_next = ((we - W'(1)) < oe) ? we - W'(1) : oe;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[3])
        begin
            go_reg <= inter_reg && (ws < we);
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    always_comb
    begin
        span = hi_reg - lo_reg + W'(1);
        if (!go_reg || (hi_reg < lo_reg))
            count_next = '0;
        else if (span > W'(dpod_pkg::COUNT_MAX))
            count_next = dpod_pkg::COUNT_MAX;
        else
            count_next = span[dpod_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld[4])
            count_reg <= count_next;
    end

    assign count = count_reg;

endmodule

/* design/date_period_overlap_days.sv */
// Top level of the date period overlap block: stream ports and pipeline control.
// Throughput is one item per cycle while the output is not stalled; two ordinal stages
// and three overlap stages each hold one item, and a stall on the output holds every
// full stage in place. Reset clears the stage valid bits only; the data registers are
// not reset.
module date_period_overlap_days #(
    parameter int YEAR_LIMIT = dpod_pkg::DEF_YEAR_LIMIT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: first_start_year, first_start_month, first_start_day,
    // first_end_year, first_end_month, first_end_day, second_start_year,
    // second_start_month, second_start_day, second_end_year, second_end_month,
    // second_end_day, then zero padding.
    input  logic [dpod_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: overlap_days, then zero padding.
    output logic [dpod_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int N = dpod_pkg::STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    dpod_pkg::pipe_ctl_t ctl;
    dpod_pkg::date_t d_s1, d_e1, d_s2, d_e2;
    logic [dpod_pkg::ORD_W-1:0] o_s1, o_e1, o_s2, o_e2;
    logic [dpod_pkg::COUNT_W-1:0] count;

    always_comb
    begin
        ctl.ld[N-1] = !valid_reg[N-1] || m_axis_tready;
        for (int i = N - 2; i >= 0; i--)
            ctl.ld[i] = !valid_reg[i] || ctl.ld[i+1];
        for (int i = 0; i < N; i++)
        begin
            if (ctl.ld[i])
                valid_next[i] = (i == 0) ? s_axis_tvalid : valid_reg[(i == 0) ? 0 : i - 1];
            else
                valid_next[i] = valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_axis_tready = ctl.ld[0];

    assign d_s1 = {s_axis_tdata[13:0], s_axis_tdata[17:14], s_axis_tdata[22:18]};
    assign d_e1 = {s_axis_tdata[36:23], s_axis_tdata[40:37], s_axis_tdata[45:41]};
    assign d_s2 = {s_axis_tdata[59:46], s_axis_tdata[63:60], s_axis_tdata[68:64]};
    assign d_e2 = {s_axis_tdata[82:69], s_axis_tdata[86:83], s_axis_tdata[91:87]};

    dpod_ordinal #(.YEAR_LIMIT(YEAR_LIMIT)) u_ord_s1 (
        .clk(clk), .ctl(ctl), .date(d_s1), .ordinal(o_s1)
    );
    dpod_ordinal #(.YEAR_LIMIT(YEAR_LIMIT)) u_ord_e1 (
        .clk(clk), .ctl(ctl), .date(d_e1), .ordinal(o_e1)
    );
    dpod_ordinal #(.YEAR_LIMIT(YEAR_LIMIT)) u_ord_s2 (
        .clk(clk), .ctl(ctl), .date(d_s2), .ordinal(o_s2)
    );
    dpod_ordinal #(.YEAR_LIMIT(YEAR_LIMIT)) u_ord_e2 (
        .clk(clk), .ctl(ctl), .date(d_e2), .ordinal(o_e2)
    );

    dpod_overlap u_overlap (
        .clk(clk),
        .ctl(ctl),
        .s1(o_s1),
        .e1(o_e1),
        .s2(o_s2),
        .e2(o_e2),
        .count(count)
    );

    assign m_axis_tvalid = valid_reg[N-1];
    assign m_axis_tdata = {{(dpod_pkg::OUT_DATA_W - dpod_pkg::COUNT_W){1'b0}}, count};

endmodule

/* design/dpod_checker.sv */
// Port-level checks of the date period overlap block and their bind.
module dpod_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [dpod_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("Output item shown during reset.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("Stalled output item dropped.");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("Input stalled while the output drains.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("Item did not reach the output in five cycles.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[dpod_pkg::OUT_DATA_W-1:dpod_pkg::COUNT_W] == '0))
        else $error("Output padding bits are not zero.");

endmodule

bind date_period_overlap_days dpod_checker u_dpod_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
